FILE: rtl/lrs_pkg.sv
// shared types and constants for the link reconnect supervisor
package lrs_pkg;

	typedef enum logic [2:0] {
		ST_IDLE       = 3'd0,
		ST_CONNECTED  = 3'd1,
		ST_WAIT       = 3'd2,
		ST_CONNECTING = 3'd3,
		ST_HARDRESET  = 3'd4,
		ST_GIVEUP     = 3'd5
	} state_t;

	typedef enum logic [2:0] {
		CMD_NONE    = 3'd0,
		CMD_BEGIN   = 3'd1,
		CMD_RETRY   = 3'd2,
		CMD_RADIO   = 3'd3,
		CMD_RESTART = 3'd4,
		CMD_APPLY   = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_TICK     = 2'd0,
		KIND_LOST     = 2'd1,
		KIND_GOT_ADDR = 2'd2,
		KIND_UNUSED   = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		REG_STATION_MODE_ON    = 3'd0,
		REG_RETRY_WAIT_MS      = 3'd1,
		REG_ATTEMPT_TIMEOUT_MS = 3'd2,
		REG_FAIL_LIMIT         = 3'd3,
		REG_GIVE_UP_MS         = 3'd4
	} reg_idx_t;

	localparam int TIME_W    = 32;
	localparam int WAIT_W    = 20;
	localparam int GIVE_UP_W = 22;
	localparam int FAIL_W    = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 22;

	localparam logic [WAIT_W-1:0]    RETRY_WAIT_RST = WAIT_W'(2000);
	localparam logic [WAIT_W-1:0]    ATTEMPT_TO_RST = WAIT_W'(15000);
	localparam logic [FAIL_W-1:0]    FAIL_LIMIT_RST = FAIL_W'(5);
	localparam logic [GIVE_UP_W-1:0] GIVE_UP_RST    = GIVE_UP_W'(180000);
	localparam logic [FAIL_W-1:0]    FAIL_MAX       = {FAIL_W{1'b1}};

endpackage

FILE: rtl/lrs_if.sv
// valid/ready channel interfaces for input events, results and register writes
interface lrs_in_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    kind;
	logic [lrs_pkg::TIME_W-1:0]    time_ms;
	logic                          link_up;

	modport source (output valid, kind, time_ms, link_up, input ready);
	modport sink (input valid, kind, time_ms, link_up, output ready);
endinterface

interface lrs_out_if;
	logic                          valid;
	logic                          ready;
	logic [2:0]                    link_state;
	logic [2:0]                    command;
	logic [lrs_pkg::FAIL_W-1:0]    failures;

	modport source (output valid, link_state, command, failures, input ready);
	modport sink (input valid, link_state, command, failures, output ready);
endinterface

interface lrs_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [lrs_pkg::CFG_IDX_W-1:0]   index;
	logic [lrs_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/link_reconnect_supervisor_core.sv
// top level of the station-link reconnect supervisor
// Each accepted event (tick, link lost, address obtained) gives exactly one result: the new
// link state, a command for the radio driver and the consecutive failure count. One event
// can be accepted every clock cycle while the output is not stalled; a result is registered
// after its transfer (the event lands in the input register, then the combinational state
// update loads the result register). While the downstream side stalls, the input and result
// registers hold up to two events before the input stalls. Time differences are taken
// modulo 2^32. Registers are written over the cfg channel, which is always ready; write them
// only while no event is in flight.
module link_reconnect_supervisor_core (
	input  logic       clk,
	input  logic       arst_n,
	lrs_in_if.sink     in_ch,
	lrs_out_if.source  out_ch,
	lrs_cfg_if.sink    cfg
);

	// configuration registers
	logic                            station_mode_q;
	logic [lrs_pkg::WAIT_W-1:0]      retry_wait_q;
	logic [lrs_pkg::WAIT_W-1:0]      attempt_to_q;
	logic [lrs_pkg::FAIL_W-1:0]      fail_limit_q;
	logic [lrs_pkg::GIVE_UP_W-1:0]   give_up_q;

	// supervisor state
	lrs_pkg::state_t                 state_q;
	logic [lrs_pkg::TIME_W-1:0]      entered_q;
	logic [lrs_pkg::TIME_W-1:0]      first_fail_q;
	logic [lrs_pkg::FAIL_W-1:0]      fail_cnt_q;

	// input register
	logic                            valid_s1;
	logic [1:0]                      kind_s1;
	logic [lrs_pkg::TIME_W-1:0]      time_s1;
	logic                            link_s1;

	// result register
	logic                            valid_s2;
	lrs_pkg::state_t                 state_s2;
	lrs_pkg::cmd_t                   cmd_s2;
	logic [lrs_pkg::FAIL_W-1:0]      fail_s2;

	logic                            adv_s2;
	logic                            adv_s1;

	lrs_pkg::state_t                 state_n;
	lrs_pkg::cmd_t                   cmd_n;
	logic [lrs_pkg::TIME_W-1:0]      entered_n;
	logic [lrs_pkg::TIME_W-1:0]      first_fail_n;
	logic [lrs_pkg::FAIL_W-1:0]      fail_cnt_n;
	logic [lrs_pkg::TIME_W-1:0]      since_enter;
	logic [lrs_pkg::TIME_W-1:0]      since_fail;

	assign adv_s2   = !valid_s2 || out_ch.ready;
	assign adv_s1   = valid_s1 && adv_s2;
	assign in_ch.ready = !valid_s1 || adv_s2;
	assign cfg.ready = 1'b1;

	assign out_ch.valid      = valid_s2;
	assign out_ch.link_state = state_s2;
	assign out_ch.command    = cmd_s2;
	assign out_ch.failures   = fail_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			station_mode_q <= 1'b1;
			retry_wait_q   <= lrs_pkg::RETRY_WAIT_RST;
			attempt_to_q   <= lrs_pkg::ATTEMPT_TO_RST;
			fail_limit_q   <= lrs_pkg::FAIL_LIMIT_RST;
			give_up_q      <= lrs_pkg::GIVE_UP_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				lrs_pkg::REG_STATION_MODE_ON:    station_mode_q <= cfg.data[0];
				lrs_pkg::REG_RETRY_WAIT_MS:      retry_wait_q <= cfg.data[lrs_pkg::WAIT_W-1:0];
				lrs_pkg::REG_ATTEMPT_TIMEOUT_MS: attempt_to_q <= cfg.data[lrs_pkg::WAIT_W-1:0];
				lrs_pkg::REG_FAIL_LIMIT:         fail_limit_q <= cfg.data[lrs_pkg::FAIL_W-1:0];
				lrs_pkg::REG_GIVE_UP_MS:         give_up_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			kind_s1 <= in_ch.kind;
			time_s1 <= in_ch.time_ms;
			link_s1 <= in_ch.link_up;
		end
	end

	assign since_enter = time_s1 - entered_q;

	always_comb begin
		state_n      = state_q;
		cmd_n        = lrs_pkg::CMD_NONE;
		entered_n    = entered_q;
		first_fail_n = first_fail_q;
		fail_cnt_n   = fail_cnt_q;
		since_fail   = '0;
		case (kind_s1)
			lrs_pkg::KIND_TICK: begin
				if (station_mode_q) begin
					unique case (state_q)
						lrs_pkg::ST_CONNECTED: begin
							if (!link_s1) begin
								state_n   = lrs_pkg::ST_WAIT;
								entered_n = time_s1;
								if (first_fail_q == '0) begin
									first_fail_n = time_s1;
								end
							end
						end
						lrs_pkg::ST_IDLE: begin
							state_n   = lrs_pkg::ST_CONNECTING;
							entered_n = time_s1;
							cmd_n     = lrs_pkg::CMD_BEGIN;
						end
						lrs_pkg::ST_WAIT: begin
							if (since_enter >= lrs_pkg::TIME_W'(retry_wait_q)) begin
								state_n   = lrs_pkg::ST_CONNECTING;
								entered_n = time_s1;
								cmd_n     = lrs_pkg::CMD_RETRY;
								if (fail_cnt_q != lrs_pkg::FAIL_MAX) begin
									fail_cnt_n = fail_cnt_q + 1'b1;
								end
							end
						end
						lrs_pkg::ST_CONNECTING: begin
							if (link_s1) begin
								state_n      = lrs_pkg::ST_CONNECTED;
								fail_cnt_n   = '0;
								first_fail_n = '0;
							end else if (since_enter > lrs_pkg::TIME_W'(attempt_to_q)) begin
								state_n   = (fail_cnt_q >= fail_limit_q) ?
									lrs_pkg::ST_HARDRESET : lrs_pkg::ST_WAIT;
								entered_n = time_s1;
							end
						end
						lrs_pkg::ST_HARDRESET: begin
							cmd_n      = lrs_pkg::CMD_RADIO;
							fail_cnt_n = '0;
							state_n    = lrs_pkg::ST_WAIT;
							entered_n  = time_s1;
						end
						default: begin
							cmd_n = lrs_pkg::CMD_RESTART;
						end
					endcase
					// give-up check runs on the failure time left after this tick
					since_fail = time_s1 - first_fail_n;
					if (state_q != lrs_pkg::ST_CONNECTED && first_fail_n != '0 &&
							since_fail > lrs_pkg::TIME_W'(give_up_q)) begin
						state_n = lrs_pkg::ST_GIVEUP;
					end
				end
			end
			lrs_pkg::KIND_LOST: begin
				if (state_q == lrs_pkg::ST_CONNECTED || state_q == lrs_pkg::ST_IDLE) begin
					first_fail_n = time_s1;
				end
				state_n   = lrs_pkg::ST_WAIT;
				entered_n = time_s1;
			end
			lrs_pkg::KIND_GOT_ADDR: begin
				state_n      = lrs_pkg::ST_CONNECTED;
				fail_cnt_n   = '0;
				first_fail_n = '0;
				cmd_n        = lrs_pkg::CMD_APPLY;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= lrs_pkg::ST_IDLE;
			entered_q    <= '0;
			first_fail_q <= '0;
			fail_cnt_q   <= '0;
		end else if (adv_s1) begin
			state_q      <= state_n;
			entered_q    <= entered_n;
			first_fail_q <= first_fail_n;
			fail_cnt_q   <= fail_cnt_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			state_s2 <= state_n;
			cmd_s2   <= cmd_n;
			fail_s2  <= fail_cnt_n;
		end
	end

endmodule
